### hw/rtl/assert_macros.svh
// Assertion macros used by the RTL files (included by nd_index_stepper_core).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Checks an implication on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Checks that an expression never holds outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif

`endif

### hw/rtl/nis_pkg.sv
package nis_pkg;

    localparam int MAX_AXES   = 4;
    localparam int INDEX_BITS = 32;
    localparam int SIZE_W     = 8;
    localparam int CNT_W      = 3;
    localparam int REG_IDX_W  = 3;
    localparam int ORDER_W    = 2 * MAX_AXES;
    // Two quotient bits are resolved per stage, eight bits per axis.
    localparam int BITS_PER_STAGE = 2;
    localparam int DIV_STAGES = MAX_AXES * SIZE_W / BITS_PER_STAGE;
    localparam int SETTLE_CYCLES = 3;

    localparam logic [REG_IDX_W-1:0] REG_AXIS_COUNT = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_SIZE_AXIS0 = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_SIZE_AXIS1 = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_SIZE_AXIS2 = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_SIZE_AXIS3 = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_ORDER      = 3'd5;

    typedef struct packed {
        logic [CNT_W-1:0]                        n;
        logic [MAX_AXES-1:0][SIZE_W-1:0]         size;
        logic [ORDER_W-1:0]                      order;
        logic [MAX_AXES-1:0][INDEX_BITS-1:0]     stride;
        logic [INDEX_BITS-1:0]                   total;
    } cfg_t;

    typedef struct packed {
        logic                                    kind;
        logic [INDEX_BITS-1:0]                   pos;
        logic                                    oor;
        logic [INDEX_BITS-1:0]                   rem;
        logic [MAX_AXES-1:0][SIZE_W-1:0]         digit;
    } div_t;

endpackage

### hw/rtl/nis_cfg.sv
module nis_cfg
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    input  logic [nis_pkg::REG_IDX_W-1:0]    cfg_index,
    input  logic [nis_pkg::SIZE_W-1:0]       cfg_data,
    output logic                             busy,
    output nis_pkg::cfg_t                    cfg
);
    import nis_pkg::*;

    logic [CNT_W-1:0]                count_reg;
    logic [MAX_AXES-1:0][SIZE_W-1:0] size_reg;
    logic [ORDER_W-1:0]              order_reg;
    logic [15:0]                     s1_reg, s1_next;
    logic [23:0]                     s0_reg, s0_next;
    logic [INDEX_BITS-1:0]           total_reg, total_next;
    logic [1:0]                      settle_reg;
    logic [CNT_W-1:0]                n_used;
    logic [MAX_AXES-1:0][SIZE_W-1:0] eff;

    always_comb
    begin
        if (count_reg == '0)
            n_used = CNT_W'(1);
        else if (count_reg > CNT_W'(MAX_AXES))
            n_used = CNT_W'(MAX_AXES);
        else
            n_used = count_reg;
        // Unused axes act as extent one so the strides stay uniform.
        for (int k = 0; k < MAX_AXES; k++)
        begin
            eff[k] = (CNT_W'(k) < n_used) ? size_reg[k] : SIZE_W'(1);
        end
        s1_next    = 16'(eff[2]) * 16'(eff[3]);
        s0_next    = 24'(s1_reg) * 24'(eff[1]);
        total_next = 32'(s0_reg) * 32'(eff[0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= CNT_W'(2);
            size_reg   <= {MAX_AXES{SIZE_W'(1)}};
            order_reg  <= 8'd228;
            s1_reg     <= 16'd1;
            s0_reg     <= 24'd1;
            total_reg  <= 32'd1;
            settle_reg <= '0;
        end
        else
        begin
            s1_reg    <= s1_next;
            s0_reg    <= s0_next;
            total_reg <= total_next;
            if (cfg_valid)
            begin
                settle_reg <= 2'(SETTLE_CYCLES);
                unique case (cfg_index)
                    REG_AXIS_COUNT: count_reg   <= cfg_data[CNT_W-1:0];
                    REG_SIZE_AXIS0: size_reg[0] <= cfg_data;
                    REG_SIZE_AXIS1: size_reg[1] <= cfg_data;
                    REG_SIZE_AXIS2: size_reg[2] <= cfg_data;
                    REG_SIZE_AXIS3: size_reg[3] <= cfg_data;
                    REG_ORDER:      order_reg   <= cfg_data;
                    default:        ;
                endcase
            end
            else if (settle_reg != '0)
            begin
                settle_reg <= settle_reg - 2'd1;
            end
        end
    end

    assign busy        = (settle_reg != '0);
    assign cfg.n       = n_used;
    assign cfg.size    = size_reg;
    assign cfg.order   = order_reg;
    assign cfg.stride[0] = 32'(s0_reg);
    assign cfg.stride[1] = 32'(s1_reg);
    assign cfg.stride[2] = 32'(eff[3]);
    assign cfg.stride[3] = 32'd1;
    assign cfg.total   = total_reg;

endmodule

### hw/rtl/nis_div.sv
module nis_div
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          load,
    input  logic                          kind,
    input  logic [nis_pkg::INDEX_BITS-1:0] position,
    input  nis_pkg::cfg_t                 cfg,
    output logic                          out_vld,
    output nis_pkg::div_t                 out_word
);
    import nis_pkg::*;

    logic [DIV_STAGES:0] vld_reg;
    div_t                st_reg [DIV_STAGES+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[DIV_STAGES-1:0], load};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_reg[0].kind  <= kind;
            st_reg[0].pos   <= position;
            st_reg[0].oor   <= (position >= cfg.total);
            st_reg[0].rem   <= position;
            st_reg[0].digit <= '0;
        end
    end

    // Restoring division: each stage resolves two quotient bits of one axis digit
    // and hands the remainder on; the next axis starts from that remainder.
    for (genvar j = 0; j < DIV_STAGES; j++)
    begin : g_step
        localparam int K  = j / (SIZE_W / BITS_PER_STAGE);
        localparam int BH = SIZE_W - 1 - BITS_PER_STAGE * (j % (SIZE_W / BITS_PER_STAGE));
        logic [INDEX_BITS:0] t_hi, t_lo;
        div_t                nx;

        always_comb
        begin
            nx   = st_reg[j];
            t_hi = {1'b0, st_reg[j].rem} - ({1'b0, cfg.stride[K]} << BH);
            if (!t_hi[INDEX_BITS])
            begin
                nx.rem          = t_hi[INDEX_BITS-1:0];
                nx.digit[K][BH] = 1'b1;
            end
            t_lo = {1'b0, nx.rem} - ({1'b0, cfg.stride[K]} << (BH - 1));
            if (!t_lo[INDEX_BITS])
            begin
                nx.rem              = t_lo[INDEX_BITS-1:0];
                nx.digit[K][BH - 1] = 1'b1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
                st_reg[j+1] <= nx;
        end
    end

    assign out_vld  = vld_reg[DIV_STAGES];
    assign out_word = st_reg[DIV_STAGES];

endmodule

### hw/rtl/nis_step.sv
module nis_step
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           en,
    input  logic                           in_vld,
    input  nis_pkg::div_t                  in_word,
    input  nis_pkg::cfg_t                  cfg,
    output logic                           out_valid,
    output logic [nis_pkg::INDEX_BITS-1:0] next_position,
    output logic                           advanced,
    output logic                           out_of_range
);
    import nis_pkg::*;

    logic [MAX_AXES-1:0][SIZE_W-1:0] d;
    logic                            stepped;
    logic [1:0]                      ax;

    logic                            a_vld_reg;
    logic [MAX_AXES-1:0][SIZE_W-1:0] a_digit_reg;
    logic [INDEX_BITS-1:0]           a_pos_reg;
    logic                            a_oor_reg;
    logic                            a_adv_reg;

    logic                            b_vld_reg;
    logic [INDEX_BITS-1:0]           b_p0_reg;
    logic [23:0]                     b_p1_reg;
    logic [15:0]                     b_p2_reg;
    logic [SIZE_W-1:0]               b_p3_reg;
    logic [INDEX_BITS-1:0]           b_pos_reg;
    logic                            b_oor_reg;
    logic                            b_adv_reg;

    logic                            c_vld_reg;
    logic [INDEX_BITS-1:0]           c_pos_reg;
    logic                            c_adv_reg;
    logic                            c_oor_reg;
    logic [INDEX_BITS-1:0]           sum;

    // Walk the order from the fastest entry until one axis steps without wrapping.
    always_comb
    begin
        d       = in_word.digit;
        stepped = 1'b0;
        ax      = '0;
        for (int e = MAX_AXES - 1; e >= 0; e--)
        begin
            if (!stepped && (CNT_W'(e) < cfg.n))
            begin
                ax = cfg.order[2*e +: 2];
                if (CNT_W'(ax) < cfg.n)
                begin
                    if (!in_word.kind)
                    begin
                        if ((9'(d[ax]) + 9'd1) < 9'(cfg.size[ax]))
                        begin
                            d[ax]   = d[ax] + SIZE_W'(1);
                            stepped = 1'b1;
                        end
                        else
                            d[ax] = '0;
                    end
                    else
                    begin
                        if (d[ax] != '0)
                        begin
                            d[ax]   = d[ax] - SIZE_W'(1);
                            stepped = 1'b1;
                        end
                        else
                            d[ax] = cfg.size[ax] - SIZE_W'(1);
                    end
                end
            end
        end
    end

    assign sum = b_p0_reg + 32'(b_p1_reg) + 32'(b_p2_reg) + 32'(b_p3_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            a_vld_reg <= in_vld;
            b_vld_reg <= a_vld_reg;
            c_vld_reg <= b_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_digit_reg <= d;
            a_pos_reg   <= in_word.pos;
            a_oor_reg   <= in_word.oor;
            a_adv_reg   <= stepped && !in_word.oor;

            b_p0_reg  <= 32'(a_digit_reg[0]) * 32'(cfg.stride[0][23:0]);
            b_p1_reg  <= 24'(a_digit_reg[1]) * 24'(cfg.stride[1][15:0]);
            b_p2_reg  <= 16'(a_digit_reg[2]) * 16'(cfg.stride[2][7:0]);
            b_p3_reg  <= a_digit_reg[3];
            b_pos_reg <= a_pos_reg;
            b_oor_reg <= a_oor_reg;
            b_adv_reg <= a_adv_reg;

            c_pos_reg <= b_oor_reg ? b_pos_reg : sum;
            c_adv_reg <= b_adv_reg;
            c_oor_reg <= b_oor_reg;
        end
    end

    assign out_valid     = c_vld_reg;
    assign next_position = c_pos_reg;
    assign advanced      = c_adv_reg;
    assign out_of_range  = c_oor_reg;

endmodule

### hw/rtl/nd_index_stepper_core.sv
// Steps a row-major linear position of an array of up to four axes one place forward
// or backward in the configured axis order, and flags positions at or above the
// element count as well as a step in which every axis wrapped. A new word is taken
// every clock cycle while the output is not stalled and the input is not held off;
// each word passes through an input range stage, 16 stages of the digit-splitting
// divider at two quotient bits each, then step, multiply and sum stages, and a
// stalled output stalls the whole pipeline.
// After any register write the input is held off while the axis strides
// and the element count are recomputed by their multiplier chain.
`include "assert_macros.svh"

module nd_index_stepper_core
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [nis_pkg::REG_IDX_W-1:0]    cfg_index,
    input  logic [nis_pkg::SIZE_W-1:0]       cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             kind,
    input  logic [nis_pkg::INDEX_BITS-1:0]   position,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [nis_pkg::INDEX_BITS-1:0]   next_position,
    output logic                             advanced,
    output logic                             out_of_range
);
    import nis_pkg::*;

    cfg_t  cfg;
    div_t  div_word;
    logic  div_vld;
    logic  busy;
    logic  en;

    assign cfg_ready = 1'b1;
    assign en        = !out_valid || out_ready;
    assign in_ready  = en && !busy && !cfg_valid;

    nis_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .busy      (busy),
        .cfg       (cfg)
    );

    nis_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .load     (in_valid && in_ready),
        .kind     (kind),
        .position (position),
        .cfg      (cfg),
        .out_vld  (div_vld),
        .out_word (div_word)
    );

    nis_step u_step
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (en),
        .in_vld        (div_vld),
        .in_word       (div_word),
        .cfg           (cfg),
        .out_valid     (out_valid),
        .next_position (next_position),
        .advanced      (advanced),
        .out_of_range  (out_of_range)
    );

    `ASSERT_NEVER(a_oor_not_adv, clk, rst_n, out_valid && out_of_range && advanced, "out of range word marked as advanced")
    `ASSERT_CLK(a_cfg_holds_input, clk, rst_n, cfg_valid |=> !in_ready, "input accepted while strides settle")
    `ASSERT_CLK(a_next_in_range, clk, rst_n, out_valid && !out_of_range && !busy |-> next_position < cfg.total, "stepped position beyond element count")

endmodule
